// ----- hw/rtl/vdu_control_code_decoder_defines.svh -----
// Assertion helpers shared by the decoder RTL.
`ifndef VDU_CONTROL_CODE_DECODER_DEFINES_SVH
`define VDU_CONTROL_CODE_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VDU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define VDU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/vdu_pkg.sv -----
package vdu_pkg;

	localparam int PARAM_DEPTH = 9;
	localparam int MAX_RESULTS = 4;

	// Control codes that act
	localparam logic [4:0] CODE_BS      = 5'd8;
	localparam logic [4:0] CODE_LF      = 5'd10;
	localparam logic [4:0] CODE_FF      = 5'd12;
	localparam logic [4:0] CODE_COLOUR  = 5'd17;
	localparam logic [4:0] CODE_GCOL    = 5'd18;
	localparam logic [4:0] CODE_PALETTE = 5'd19;
	localparam logic [4:0] CODE_MODE    = 5'd22;
	localparam logic [4:0] CODE_DEFCHR  = 5'd23;
	localparam logic [4:0] CODE_PLOT    = 5'd25;
	localparam logic [4:0] CODE_HOME    = 5'd30;
	localparam logic [4:0] CODE_TAB     = 5'd31;

	// Plot shape selector (mode >> 3)
	localparam logic [4:0] SHAPE_LINE = 5'd0;
	localparam logic [4:0] SHAPE_DOT  = 5'd8;
	localparam logic [4:0] SHAPE_TRI  = 5'd10;

	// Plot colour selector (mode bits 1..0)
	localparam logic [1:0] PCOL_NONE = 2'd0;
	localparam logic [1:0] PCOL_FG   = 2'd1;
	localparam logic [1:0] PCOL_INV  = 2'd2;
	localparam logic [1:0] PCOL_BG   = 2'd3;

	localparam logic [7:0]  INVERT_COLOUR = 8'h3f;
	localparam logic [7:0]  MAX_MODE      = 8'd4;
	localparam logic [7:0]  MONO_MODE     = 8'd2;
	localparam logic [9:0]  TOP_Y_TALL    = 10'd1023;
	localparam logic [9:0]  TOP_Y_STD     = 10'd959;
	localparam logic [10:0] NARROW_WIDTH  = 11'd320;
	localparam logic [10:0] TALL_HEIGHT   = 11'd256;
	localparam logic [10:0] HIRES_HEIGHT  = 11'd400;

	typedef enum logic [3:0] {
		CMD_CHAR    = 4'd0,
		CMD_COLOUR  = 4'd1,
		CMD_PALETTE = 4'd2,
		CMD_MODE    = 4'd3,
		CMD_GLYPH   = 4'd4,
		CMD_LINE    = 4'd5,
		CMD_DOT     = 4'd6,
		CMD_TRI     = 4'd7,
		CMD_CURSOR  = 4'd8
	} cmd_t;

	typedef logic [3:0] pidx_t;
	typedef logic [7:0] param_arr_t [PARAM_DEPTH];

	typedef struct packed {
		logic [15:0] y;
		logic [15:0] x;
	} point_t;

	typedef struct packed {
		logic [4:0] pending_code;
		logic [3:0] param_count;
		logic [3:0] params_expected;
		logic [5:0] text_fg;
		logic [5:0] text_bg;
		logic [5:0] draw_fg;
		logic [5:0] draw_bg;
		logic [7:0] mono_fg;
		logic [7:0] mono_bg;
		point_t     prev_point;
		point_t     older_point;
		logic [9:0] top_y;
		logic [1:0] shift_x;
		logic [1:0] shift_y;
	} state_t;

	localparam state_t STATE_RESET = '{
		pending_code:    5'd0,
		param_count:     4'd0,
		params_expected: 4'd0,
		text_fg:         6'd3,
		text_bg:         6'd0,
		draw_fg:         6'd7,
		draw_bg:         6'd0,
		mono_fg:         8'd7,
		mono_bg:         8'd0,
		prev_point:      '0,
		older_point:     '0,
		top_y:           TOP_Y_STD,
		shift_x:         2'd1,
		shift_y:         2'd2
	};

	typedef struct packed {
		cmd_t               command;
		logic signed [15:0] x_a;
		logic signed [15:0] y_a;
		logic signed [15:0] x_b;
		logic signed [15:0] y_b;
		logic signed [15:0] x_c;
		logic signed [15:0] y_c;
		logic [7:0]         value_a;
		logic [7:0]         value_b;
		logic               invert;
		logic [63:0]        glyph_rows;
	} result_t;

	// Parameter bytes each control code collects before it acts
	function automatic logic [3:0] param_len(logic [4:0] code);
		logic [3:0] n;
		unique case (code)
			5'd1, 5'd17, 5'd22: n = 4'd1;
			5'd18, 5'd31:       n = 4'd2;
			5'd19, 5'd25:       n = 4'd5;
			5'd23:              n = 4'd9;
			5'd24:              n = 4'd8;
			5'd28, 5'd29:       n = 4'd4;
			default:            n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic result_t simple_res(cmd_t cmd, logic [7:0] va, logic [7:0] vb);
		result_t r;
		r = '0;
		r.command = cmd;
		r.value_a = va;
		r.value_b = vb;
		return r;
	endfunction

	// Floor shift of the signed x coordinate
	function automatic logic signed [15:0] scale_x(point_t p, logic [1:0] sh);
		logic signed [15:0] xs;
		xs = $signed(p.x);
		return xs >>> sh;
	endfunction

	// Flip against top_y, then floor shift
	function automatic logic signed [15:0] scale_y(point_t p, logic [9:0] top,
		logic [1:0] sh);
		logic signed [16:0] d;
		logic signed [16:0] q;
		d = $signed({7'b0, top}) - $signed({p.y[15], p.y});
		q = d >>> sh;
		return q[15:0];
	endfunction

endpackage

// ----- hw/rtl/vdu_in_if.sv -----
interface vdu_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  code_byte;
	logic [10:0] display_width;
	logic [10:0] display_height;

	modport source (output valid, code_byte, display_width, display_height, input ready);
	modport sink (input valid, code_byte, display_width, display_height, output ready);
endinterface

// ----- hw/rtl/vdu_out_if.sv -----
interface vdu_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         command;
	logic signed [15:0] x_a;
	logic signed [15:0] y_a;
	logic signed [15:0] x_b;
	logic signed [15:0] y_b;
	logic signed [15:0] x_c;
	logic signed [15:0] y_c;
	logic [7:0]         value_a;
	logic [7:0]         value_b;
	logic               invert;
	logic [63:0]        glyph_rows;
	logic               last;

	modport source (output valid, command, x_a, y_a, x_b, y_b, x_c, y_c, value_a, value_b,
		invert, glyph_rows, last, input ready);
	modport sink (input valid, command, x_a, y_a, x_b, y_b, x_c, y_c, value_a, value_b,
		invert, glyph_rows, last, output ready);
endinterface

// ----- hw/rtl/vdu_decode.sv -----
module vdu_decode (
	input  logic [7:0]                                 code_byte,
	input  logic [10:0]                                display_width,
	input  logic [10:0]                                display_height,
	input  vdu_pkg::state_t                            st,
	input  vdu_pkg::param_arr_t                        params,
	output vdu_pkg::state_t                            st_next,
	output logic                                       wr_en,
	output vdu_pkg::pidx_t                             wr_idx,
	output vdu_pkg::result_t [vdu_pkg::MAX_RESULTS-1:0] res,
	output logic [2:0]                                 res_n
);
	import vdu_pkg::*;

	param_arr_t p;
	logic [3:0] cnt_inc;
	logic       go;
	logic [4:0] code;
	point_t     np;
	logic [15:0] dx, dy;
	logic [7:0] colour;
	logic       inv;
	logic       draw;
	logic [2:0] n;

	// Store write for a parameter byte
	assign wr_en  = (st.params_expected != 4'd0) && (st.param_count < 4'(PARAM_DEPTH));
	assign wr_idx = st.param_count;

	// Parameter view including the byte being written now
	always_comb begin
		for (int i = 0; i < PARAM_DEPTH; i++) begin
			p[i] = (wr_en && wr_idx == pidx_t'(i)) ? code_byte : params[i];
		end
	end

	// Plot geometry
	assign dx = {p[2], p[1]};
	assign dy = {p[4], p[3]};
	always_comb begin
		if (p[0][2]) begin
			np.x = dx;
			np.y = dy;
		end else begin
			np.x = st.prev_point.x + dx;
			np.y = st.prev_point.y + dy;
		end
	end

	// Plot colour
	always_comb begin
		colour = 8'd0;
		inv    = 1'b0;
		draw   = 1'b1;
		unique case (p[0][1:0])
			PCOL_FG:  colour = {2'b0, st.draw_fg};
			PCOL_INV: begin
				colour = INVERT_COLOUR;
				inv    = 1'b1;
			end
			PCOL_BG:  colour = {2'b0, st.draw_bg};
			default:  draw = 1'b0;
		endcase
	end

	// Byte routing, parameter collection and actions
	always_comb begin
		st_next = st;
		res     = '0;
		n       = 3'd0;
		go      = 1'b0;
		code    = code_byte[4:0];
		cnt_inc = st.param_count + 4'd1;

		if (st.params_expected != 4'd0) begin
			if (cnt_inc >= st.params_expected) begin
				st_next.params_expected = 4'd0;
				st_next.param_count     = 4'd0;
				go   = 1'b1;
				code = st.pending_code;
			end else begin
				st_next.param_count = cnt_inc;
			end
		end else if (code_byte < 8'd32) begin
			if (param_len(code_byte[4:0]) != 4'd0) begin
				st_next.pending_code    = code_byte[4:0];
				st_next.params_expected = param_len(code_byte[4:0]);
				st_next.param_count     = 4'd0;
			end else begin
				go = 1'b1;
			end
		end else if (code_byte[7]) begin
			res[0] = simple_res(CMD_CHAR, {3'b111, code_byte[4:0]}, 8'd0);
			n = 3'd1;
		end else begin
			res[0] = simple_res(CMD_CHAR, code_byte, 8'd0);
			n = 3'd1;
		end

		if (go) begin
			unique case (code)
				CODE_BS, CODE_LF, CODE_FF: begin
					res[0] = simple_res(CMD_CHAR, {3'b0, code}, 8'd0);
					n = 3'd1;
				end
				CODE_COLOUR: begin
					if (p[0][7]) st_next.text_bg = p[0][5:0];
					else st_next.text_fg = p[0][5:0];
					res[0] = simple_res(CMD_COLOUR, {2'b0, st_next.text_fg},
						{2'b0, st_next.text_bg});
					n = 3'd1;
				end
				CODE_GCOL: begin
					if (p[1][7]) st_next.draw_bg = p[1][5:0];
					else st_next.draw_fg = p[1][5:0];
				end
				CODE_PALETTE: begin
					if (p[0] == 8'd0) st_next.mono_bg = p[1];
					else st_next.mono_fg = p[1];
					res[0] = simple_res(CMD_PALETTE, st_next.mono_fg, st_next.mono_bg);
					n = 3'd1;
				end
				CODE_MODE: begin
					if (p[0] <= MAX_MODE) begin
						if (p[0] == MONO_MODE) begin
							res[n[1:0]] = simple_res(CMD_PALETTE, 8'd7, 8'd0);
							n = n + 3'd1;
						end
						res[n[1:0]] = simple_res(CMD_MODE, p[0], 8'd0);
						n = n + 3'd1;
						res[n[1:0]] = simple_res(CMD_CHAR, {3'b0, CODE_FF}, 8'd0);
						n = n + 3'd1;
						res[n[1:0]] = simple_res(CMD_COLOUR, 8'd7, 8'd0);
						n = n + 3'd1;
						st_next.text_fg = 6'd7;
						st_next.text_bg = 6'd0;
						st_next.draw_fg = 6'd7;
						st_next.draw_bg = 6'd0;
						st_next.mono_fg = 8'd7;
						st_next.mono_bg = 8'd0;
					end
					st_next.top_y   = (display_height == TALL_HEIGHT) ? TOP_Y_TALL : TOP_Y_STD;
					st_next.shift_x = (display_width == NARROW_WIDTH) ? 2'd2 : 2'd1;
					st_next.shift_y = (display_height < HIRES_HEIGHT) ? 2'd2 : 2'd1;
					st_next.prev_point  = '0;
					st_next.older_point = '0;
				end
				CODE_DEFCHR: begin
					if (p[0][7]) begin
						res[0] = simple_res(CMD_GLYPH, {3'b111, p[0][4:0]}, 8'd0);
						res[0].glyph_rows = {p[8], p[7], p[6], p[5], p[4], p[3], p[2], p[1]};
						n = 3'd1;
					end
				end
				CODE_PLOT: begin
					if (draw) begin
						res[0].x_a     = scale_x(np, st.shift_x);
						res[0].y_a     = scale_y(np, st.top_y, st.shift_y);
						res[0].value_a = colour;
						res[0].invert  = inv;
						unique case (p[0][7:3])
							SHAPE_LINE: begin
								res[0].command = CMD_LINE;
								res[0].x_b = scale_x(st.prev_point, st.shift_x);
								res[0].y_b = scale_y(st.prev_point, st.top_y, st.shift_y);
								n = 3'd1;
							end
							SHAPE_DOT: begin
								res[0].command = CMD_DOT;
								n = 3'd1;
							end
							SHAPE_TRI: begin
								res[0].command = CMD_TRI;
								res[0].x_b = scale_x(st.prev_point, st.shift_x);
								res[0].y_b = scale_y(st.prev_point, st.top_y, st.shift_y);
								res[0].x_c = scale_x(st.older_point, st.shift_x);
								res[0].y_c = scale_y(st.older_point, st.top_y, st.shift_y);
								n = 3'd1;
							end
							default: n = 3'd0;
						endcase
					end
					st_next.older_point = st.prev_point;
					st_next.prev_point  = np;
				end
				CODE_HOME: begin
					res[0] = simple_res(CMD_CURSOR, 8'd0, 8'd0);
					n = 3'd1;
				end
				CODE_TAB: begin
					res[0] = simple_res(CMD_CURSOR, p[0], p[1]);
					n = 3'd1;
				end
				default: n = 3'd0;
			endcase
		end
		res_n = n;
	end

endmodule

// ----- hw/rtl/vdu_control_code_decoder.sv -----
// VDU control code decoder. Takes one VDU stream byte per transfer on stream and
// delivers action commands on action, one per transfer, with last set on the final
// command that a byte causes. A byte sits in the input register, where the whole
// decode and state update happens, and its zero to four commands (four on a mode 2
// switch) then wait in a result buffer that drains one command per cycle while
// action is ready. Parameter bytes and other bytes without commands retire at one
// per cycle, also while earlier commands are queued; a byte with commands waits in
// the input register until the buffer is empty or its last command transfers.
// Display width and height travel with every byte and are only read when a mode
// switch completes. Parameter store entries never written read as don't-care.
`include "vdu_control_code_decoder_defines.svh"

module vdu_control_code_decoder (
	input logic     clk,
	input logic     arst_n,
	vdu_in_if.sink  stream,
	vdu_out_if.source action
);
	import vdu_pkg::*;

	// Input register
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic [10:0] width_s1;
	logic [10:0] height_s1;

	// Decoder state
	state_t      st_q;
	param_arr_t  store_q;

	// Result buffer
	result_t [MAX_RESULTS-1:0] buf_q;
	logic [2:0] buf_cnt_q;
	logic [1:0] buf_idx_q;

	state_t     st_next;
	logic       wr_en;
	pidx_t      wr_idx;
	result_t [MAX_RESULTS-1:0] res;
	logic [2:0] res_n;
	logic       out_xfer;
	logic       out_last;
	logic       buf_free;
	logic       adv_s1;
	result_t    cur;

	vdu_decode u_decode (
		.code_byte      (byte_s1),
		.display_width  (width_s1),
		.display_height (height_s1),
		.st             (st_q),
		.params         (store_q),
		.st_next        (st_next),
		.wr_en          (wr_en),
		.wr_idx         (wr_idx),
		.res            (res),
		.res_n          (res_n)
	);

	// Handshake control
	assign out_last = buf_idx_q == 2'(buf_cnt_q - 3'd1);
	assign out_xfer = action.valid && action.ready;
	assign buf_free = (buf_cnt_q == 3'd0) || (out_xfer && out_last);
	assign adv_s1   = v_s1 && ((res_n == 3'd0) || buf_free);
	assign stream.ready = !v_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (stream.ready) begin
			v_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1   <= stream.code_byte;
			width_s1  <= stream.display_width;
			height_s1 <= stream.display_height;
		end
	end

	// State update on retire
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (adv_s1) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && wr_en) begin
			store_q[wr_idx] <= byte_s1;
		end
	end

	// Result buffer fill and drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= 3'd0;
			buf_idx_q <= 2'd0;
		end else begin
			if (out_xfer) begin
				if (out_last) begin
					buf_cnt_q <= 3'd0;
					buf_idx_q <= 2'd0;
				end else begin
					buf_idx_q <= buf_idx_q + 2'd1;
				end
			end
			if (adv_s1 && res_n != 3'd0) begin
				buf_cnt_q <= res_n;
				buf_idx_q <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_n != 3'd0) begin
			buf_q <= res;
		end
	end

	// Output payload
	assign cur               = buf_q[buf_idx_q];
	assign action.valid      = buf_cnt_q != 3'd0;
	assign action.command    = cur.command;
	assign action.x_a        = cur.x_a;
	assign action.y_a        = cur.y_a;
	assign action.x_b        = cur.x_b;
	assign action.y_b        = cur.y_b;
	assign action.x_c        = cur.x_c;
	assign action.y_c        = cur.y_c;
	assign action.value_a    = cur.value_a;
	assign action.value_b    = cur.value_b;
	assign action.invert     = cur.invert;
	assign action.glyph_rows = cur.glyph_rows;
	assign action.last       = out_last;

	// Checks
	`VDU_ASSERT_NOW(a_idx_in_range, action.valid, {1'b0, buf_idx_q} < buf_cnt_q, "result index past buffer fill")
	`VDU_ASSERT_NEXT(a_s1_hold, v_s1 && !adv_s1, v_s1 && $stable(byte_s1), "stalled input byte lost")
	`VDU_ASSERT_NOW(a_idle_count, st_q.params_expected == 4'd0, st_q.param_count == 4'd0, "param count without pending code")
	`VDU_ASSERT_NOW(a_count_bound, st_q.params_expected != 4'd0, st_q.param_count < st_q.params_expected, "param count overran expected")

endmodule
